// ----- rtl/core/mmt_pkg.sv -----
// mmt_pkg: shared codes and controller/datapath interface structs
// for the multicast membership table; no dependencies
package mmt_pkg;

  // function codes of an input item
  localparam logic [2:0] FN_JOIN  = 3'd0;
  localparam logic [2:0] FN_LEAVE = 3'd1;
  localparam logic [2:0] FN_AGE   = 3'd2;
  localparam logic [2:0] FN_DROP  = 3'd3;
  localparam logic [2:0] FN_FWD   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_REFRESHED  = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_AGED       = 3'd5;
  localparam logic [2:0] ST_TARGET     = 3'd6;
  localparam logic [2:0] ST_NO_TARGETS = 3'd7;

  localparam logic [15:0] TIMEOUT_RESET = 16'd260;
  localparam int unsigned TGT_DEPTH = 64;
  localparam logic [8:0] CNT_MAX = 9'd511;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_step;
    logic commit;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic req_scan;
    logic out_free;
    logic emit_last;
  } stat_t;

endpackage

// ----- rtl/core/mmt_datapath.sv -----
// mmt_datapath: membership memory, scan evaluation, target buffer and
// output register; depends on mmt_pkg
module mmt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned NUM_INSTANCES = 64,
  parameter int unsigned ADDR_BITS     = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mmt_pkg::cmd_t        cmd_i,
  output mmt_pkg::stat_t       stat_o,
  input  logic                 cfg_valid_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [2:0]           func_i,
  input  logic [31:0]          group_addr_i,
  input  logic [ADDR_BITS-1:0] recipient_addr_i,
  input  logic [5:0]           instance_req_i,
  input  logic [6:0]           omit_instance_i,
  input  logic [63:0]          halted_mask_i,
  input  logic [31:0]          now_time_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [2:0]           status_o,
  output logic [5:0]           target_instance_o,
  output logic [8:0]           removed_count_o,
  output logic                 last_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned WW = 71 + ADDR_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [6:0] NUM_INST = 7'(NUM_INSTANCES);

  // word layout: rcpt | group | owner | expiry | valid
  logic [WW-1:0] mem_q [TABLE_ENTRIES];
  logic [WW-1:0] rd_word_q;
  logic          s1_v_q;
  logic [AW-1:0] s1_idx_q;
  logic [AW-1:0] cnt_q;

  logic [15:0]          tmo_q;
  logic [2:0]           op_q;
  logic [31:0]          grp_q;
  logic [ADDR_BITS-1:0] rcpt_q;
  logic [5:0]           inst_q;
  logic [6:0]           omit_q;
  logic [63:0]          halt_q;
  logic [31:0]          now_q;
  logic                 bad_q;

  logic [8:0]    rm_cnt_q;
  logic          found_q, free_found_q;
  logic [AW-1:0] match_idx_q, free_idx_q;
  logic [5:0]    match_own_q;
  logic [63:0]   seen_q;
  logic [6:0]    tcnt_q, ptr_q;
  logic [5:0]    tbuf_q [mmt_pkg::TGT_DEPTH];
  logic [5:0]    tbuf_rd_q;
  logic [5:0]    tbuf_ra;

  logic                 e_valid;
  logic [31:0]          e_exp;
  logic [5:0]           e_own;
  logic [31:0]          e_grp;
  logic [ADDR_BITS-1:0] e_rcpt;
  logic is_join, is_leave, is_drop, is_fwd, sweep_op;
  logic rm, live, match, fwd_hit;
  logic [32:0] sum;
  logic [31:0] expiry;
  logic          we;
  logic [AW-1:0] wa;
  logic [WW-1:0] wd;
  logic          out_valid_q, last_q;
  logic [2:0]    status_q;
  logic [5:0]    tgt_q;
  logic [8:0]    cnt_out_q;
  logic [2:0]    st_n;
  logic          emit_last;

  assign e_valid = rd_word_q[0];
  assign e_exp   = rd_word_q[32:1];
  assign e_own   = rd_word_q[38:33];
  assign e_grp   = rd_word_q[70:39];
  assign e_rcpt  = rd_word_q[WW-1:71];

  assign is_join  = (op_q == mmt_pkg::FN_JOIN);
  assign is_leave = (op_q == mmt_pkg::FN_LEAVE);
  assign is_drop  = (op_q == mmt_pkg::FN_DROP);
  assign is_fwd   = (op_q == mmt_pkg::FN_FWD);
  assign sweep_op = !is_fwd && !bad_q;

  // per-entry evaluation on the registered read
  assign rm      = s1_v_q && sweep_op && e_valid && (e_own == inst_q) &&
                   (is_drop || (e_exp <= now_q));
  assign live    = e_valid && !rm;
  assign match   = live && (e_grp == grp_q) && (e_rcpt == rcpt_q);
  assign fwd_hit = s1_v_q && is_fwd && e_valid && (e_grp == grp_q) &&
                   ({1'b0, e_own} != omit_q) && !halt_q[e_own] && !seen_q[e_own];

  // saturating expiry
  assign sum    = {1'b0, now_q} + {17'b0, tmo_q};
  assign expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  // memory write port select
  always_comb begin
    we = 1'b0;
    wa = cnt_q;
    wd = '0;
    if (cmd_i.clear_step) begin
      we = 1'b1;
    end else if (rm) begin
      we = 1'b1;
      wa = s1_idx_q;
      wd = {rd_word_q[WW-1:1], 1'b0};
    end else if (cmd_i.commit && !bad_q) begin
      if (is_leave && found_q) begin
        we = 1'b1;
        wa = match_idx_q;
        wd = {rcpt_q, grp_q, match_own_q, expiry, 1'b0};
      end else if (is_join && found_q) begin
        we = 1'b1;
        wa = match_idx_q;
        wd = {rcpt_q, grp_q, match_own_q, expiry, 1'b1};
      end else if (is_join && free_found_q) begin
        we = 1'b1;
        wa = free_idx_q;
        wd = {rcpt_q, grp_q, inst_q, expiry, 1'b1};
      end
    end
  end

  // membership memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_word_q <= mem_q[cnt_q];
  end

  // scan address and read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      s1_v_q   <= 1'b0;
      s1_idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.clear_step || cmd_i.scan_step) begin
        cnt_q <= cnt_q + AW'(1);
      end
      s1_v_q   <= cmd_i.scan_step;
      s1_idx_q <= cnt_q;
    end
  end

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= mmt_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      tmo_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= func_i;
      grp_q  <= group_addr_i;
      rcpt_q <= recipient_addr_i;
      inst_q <= instance_req_i;
      omit_q <= omit_instance_i;
      halt_q <= halted_mask_i;
      now_q  <= now_time_i;
      bad_q  <= !stat_o.req_scan;
    end
  end

  // scan accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rm_cnt_q     <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      match_idx_q  <= '0;
      free_idx_q   <= '0;
      match_own_q  <= '0;
      seen_q       <= '0;
      tcnt_q       <= '0;
    end else if (cmd_i.load) begin
      rm_cnt_q     <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      seen_q       <= '0;
      tcnt_q       <= '0;
    end else if (s1_v_q) begin
      if (rm && rm_cnt_q != mmt_pkg::CNT_MAX) begin
        rm_cnt_q <= rm_cnt_q + 9'd1;
      end
      if (sweep_op && match && !found_q) begin
        found_q     <= 1'b1;
        match_idx_q <= s1_idx_q;
        match_own_q <= e_own;
      end
      if (sweep_op && !live && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= s1_idx_q;
      end
      if (fwd_hit) begin
        seen_q[e_own] <= 1'b1;
        tcnt_q        <= tcnt_q + 7'd1;
      end
    end
  end

  // target buffer, read one ahead of the output
  assign tbuf_ra = cmd_i.emit ? 6'(ptr_q + 7'd1) : ptr_q[5:0];

  always_ff @(posedge clk_i) begin
    if (fwd_hit) begin
      tbuf_q[tcnt_q[5:0]] <= e_own;
    end
    tbuf_rd_q <= tbuf_q[tbuf_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.load) begin
      ptr_q <= '0;
    end else if (cmd_i.emit) begin
      ptr_q <= ptr_q + 7'd1;
    end
  end

  // result status
  always_comb begin
    if (bad_q) begin
      st_n = mmt_pkg::ST_NOT_FOUND;
    end else if (is_fwd) begin
      st_n = (tcnt_q == 7'd0) ? mmt_pkg::ST_NO_TARGETS : mmt_pkg::ST_TARGET;
    end else if (is_leave) begin
      st_n = found_q ? mmt_pkg::ST_REMOVED : mmt_pkg::ST_NOT_FOUND;
    end else if (is_join) begin
      st_n = found_q ? mmt_pkg::ST_REFRESHED :
             (free_found_q ? mmt_pkg::ST_ADDED : mmt_pkg::ST_FULL);
    end else begin
      st_n = mmt_pkg::ST_AGED;
    end
  end

  assign emit_last = bad_q || !is_fwd || (tcnt_q == 7'd0) ||
                     (ptr_q == tcnt_q - 7'd1);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q  <= st_n;
      tgt_q     <= (st_n == mmt_pkg::ST_TARGET) ? tbuf_rd_q : 6'd0;
      cnt_out_q <= (bad_q || is_fwd) ? 9'd0 : rm_cnt_q;
      last_q    <= emit_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign target_instance_o = tgt_q;
  assign removed_count_o   = cnt_out_q;
  assign last_o            = last_q;

  assign stat_o.cnt_last  = (cnt_q == LAST_IDX);
  assign stat_o.req_scan  = (func_i == mmt_pkg::FN_FWD) ||
                            ((func_i <= mmt_pkg::FN_DROP) &&
                             ({1'b0, instance_req_i} < NUM_INST));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign stat_o.emit_last = emit_last;

endmodule

// ----- rtl/core/mmt_ctrl.sv -----
// mmt_ctrl: sequencer for clearing, scanning, commit and result emission
// depends on mmt_pkg
module mmt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mmt_pkg::stat_t stat_i,
  output mmt_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_RESP
  } state_e;

  state_e state_q;
  logic   stall_q;
  logic   accept;

  assign accept = (state_q == S_IDLE) && in_valid_i && !stall_q;

  // commands decoded from state
  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (state_q == S_CLEAR);
    cmd_o.load       = accept;
    cmd_o.scan_step  = (state_q == S_SCAN);
    cmd_o.commit     = (state_q == S_COMMIT);
    cmd_o.emit       = (state_q == S_RESP) && stat_i.out_free;
  end

  // state and stall register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      stall_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_CLEAR: begin
          if (stat_i.cnt_last) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= stat_i.req_scan ? S_SCAN : S_RESP;
            stall_q <= 1'b1;
          end
        end
        S_SCAN: begin
          if (stat_i.cnt_last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN:  state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_RESP;
        S_RESP: begin
          if (stat_i.out_free && stat_i.emit_last) begin
            state_q <= S_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o = stall_q;

endmodule

// ----- rtl/core/multicast_membership_table.sv -----
// multicast_membership_table: top level joining controller and datapath
// depends on mmt_pkg, mmt_ctrl, mmt_datapath
//
//  channel | direction | handshake          | transfer
//  in      | input     | in_valid / stall   | one request item
//  out     | output    | out_valid / stall  | one result item
//  cfg     | input     | cfg_valid / ready  | timeout_interval write
//
// each scanning request walks the whole table once over the single-port
// memory; the first result is registered after the scan, drain and commit
// states, and a new request waits until the last result is emitted.
// requests that name no valid instance or function skip the scan.
// forward emits one result per unstalled cycle from the target buffer.
// after reset a clearing pass over every table entry holds in_stall high.
// an output stall holds the result register and pauses result emission.
module multicast_membership_table #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned NUM_INSTANCES = 64,
  parameter int unsigned ADDR_BITS     = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           func_i,
  input  logic [31:0]          group_addr_i,
  input  logic [ADDR_BITS-1:0] recipient_addr_i,
  input  logic [5:0]           instance_req_i,
  input  logic [6:0]           omit_instance_i,
  input  logic [63:0]          halted_mask_i,
  input  logic [31:0]          now_time_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [5:0]           target_instance_o,
  output logic [8:0]           removed_count_o,
  output logic                 last_o
);

  mmt_pkg::cmd_t  cmd;
  mmt_pkg::stat_t stat;

  // configuration writes are taken at any time
  assign cfg_ready_o = 1'b1;

  mmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mmt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NUM_INSTANCES (NUM_INSTANCES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .func_i            (func_i),
    .group_addr_i      (group_addr_i),
    .recipient_addr_i  (recipient_addr_i),
    .instance_req_i    (instance_req_i),
    .omit_instance_i   (omit_instance_i),
    .halted_mask_i     (halted_mask_i),
    .now_time_i        (now_time_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .target_instance_o (target_instance_o),
    .removed_count_o   (removed_count_o),
    .last_o            (last_o)
  );

endmodule

// ----- rtl/core/mmt_checker.sv -----
// mmt_checker: port-level assertions for the membership table, with bind
// depends on mmt_pkg and the multicast_membership_table ports
module mmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [5:0] target_instance_o,
  input logic [8:0] removed_count_o,
  input logic       last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(target_instance_o) && $stable(removed_count_o) && $stable(last_o))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // clearing pass follows reset
  a_clear: assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o)
    else $error("input open during clearing");

  // no targets is a lone final result
  a_no_tgt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == mmt_pkg::ST_NO_TARGETS |-> last_o &&
    target_instance_o == 6'd0 && removed_count_o == 9'd0)
    else $error("bad no-targets result");

endmodule

bind multicast_membership_table mmt_checker u_mmt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .target_instance_o (target_instance_o),
  .removed_count_o   (removed_count_o),
  .last_o            (last_o)
);

// ----- bench/multicast_membership_table_tb.sv -----
// multicast_membership_table_tb: self-checking bench for the membership table
// depends on mmt_pkg and multicast_membership_table; predicts every result
// from its own copy of the table and checks each result transfer in order
module multicast_membership_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES   = 256;
  localparam int unsigned SETTLE    = 300;
  localparam int unsigned MAX_CYCLE = 1500000;
  localparam logic [2:0]  FN_BAD5   = 3'd5;
  localparam logic [2:0]  FN_BAD7   = 3'd7;
  localparam logic [6:0]  OMIT_NONE = 7'd64;
  localparam logic [6:0]  OMIT_TOP  = 7'd127;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] grp;
    logic [47:0] rcpt;
    logic [5:0]  inst;
    logic [6:0]  omit;
    logic [63:0] halted;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] tgt;
    logic [8:0] cnt;
    logic       last;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [31:0] group_addr_i = '0;
  logic [47:0] recipient_addr_i = '0;
  logic [5:0]  instance_req_i = '0;
  logic [6:0]  omit_instance_i = '0;
  logic [63:0] halted_mask_i = '0;
  logic [31:0] now_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  target_instance_o;
  logic [8:0]  removed_count_o;
  logic        last_o;

  multicast_membership_table DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .func_i, .group_addr_i, .recipient_addr_i,
    .instance_req_i, .omit_instance_i, .halted_mask_i, .now_time_i,
    .out_valid_o, .out_stall_i, .status_o, .target_instance_o,
    .removed_count_o, .last_o
  );

  // membership table mirror
  logic        mem_valid [ENTRIES];
  logic [31:0] mem_group [ENTRIES];
  logic [47:0] mem_rcpt  [ENTRIES];
  logic [5:0]  mem_owner [ENTRIES];
  logic [31:0] mem_expiry[ENTRIES];
  logic [15:0] timeout_val = mmt_pkg::TIMEOUT_RESET;

  req_t        pend_q[$];
  res_t        expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned cfg_writes = 0;
  logic        in_acc = 1'b0;
  logic [31:0] cur_now = 32'd1000;

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_result(logic [2:0] st, logic [5:0] tgt, int cnt, logic lst);
    res_t r;
    r.status = st;
    r.tgt    = tgt;
    r.cnt    = (cnt > 511) ? mmt_pkg::CNT_MAX : cnt[8:0];
    r.last   = lst;
    expected_q.push_back(r);
  endfunction

  // remove one instance's members, all or only the expired ones
  function automatic int sweep_members(logic [5:0] inst, logic [31:0] now, bit all);
    int n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (mem_valid[i] && mem_owner[i] == inst && (all || mem_expiry[i] <= now)) begin
        mem_valid[i] = 1'b0;
        n++;
      end
    return n;
  endfunction

  // update the mirror and queue the results one request causes
  function automatic void predict_membership(req_t r);
    logic [32:0] sum;
    logic [31:0] expiry;
    logic [63:0] seen;
    logic [5:0]  tl[$];
    logic [5:0]  o;
    int          aged;
    int          slot;
    sum    = {1'b0, r.now} + {17'd0, timeout_val};
    expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (r.func == mmt_pkg::FN_FWD) begin
      seen = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!mem_valid[i] || mem_group[i] != r.grp) continue;
        o = mem_owner[i];
        if ({1'b0, o} == r.omit || r.halted[o] || seen[o]) continue;
        seen[o] = 1'b1;
        tl.push_back(o);
      end
      if (tl.size() == 0) push_result(mmt_pkg::ST_NO_TARGETS, '0, 0, 1'b1);
      for (int i = 0; i < tl.size(); i++)
        push_result(mmt_pkg::ST_TARGET, tl[i], 0, i == tl.size() - 1);
      return;
    end
    if (r.func > mmt_pkg::FN_FWD) begin
      push_result(mmt_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
      return;
    end
    if (r.func == mmt_pkg::FN_AGE || r.func == mmt_pkg::FN_DROP) begin
      push_result(mmt_pkg::ST_AGED, '0,
                  sweep_members(r.inst, r.now, r.func == mmt_pkg::FN_DROP), 1'b1);
      return;
    end
    aged = sweep_members(r.inst, r.now, 1'b0);
    slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && mem_valid[i] && mem_group[i] == r.grp && mem_rcpt[i] == r.rcpt)
        slot = i;
    if (r.func == mmt_pkg::FN_LEAVE) begin
      if (slot < 0) push_result(mmt_pkg::ST_NOT_FOUND, '0, aged, 1'b1);
      else begin
        mem_valid[slot] = 1'b0;
        push_result(mmt_pkg::ST_REMOVED, '0, aged, 1'b1);
      end
      return;
    end
    if (slot >= 0) begin
      mem_expiry[slot] = expiry;
      push_result(mmt_pkg::ST_REFRESHED, '0, aged, 1'b1);
      return;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (!mem_valid[i]) begin
        mem_valid[i]  = 1'b1;
        mem_group[i]  = r.grp;
        mem_rcpt[i]   = r.rcpt;
        mem_owner[i]  = r.inst;
        mem_expiry[i] = expiry;
        push_result(mmt_pkg::ST_ADDED, '0, aged, 1'b1);
        return;
      end
    push_result(mmt_pkg::ST_FULL, '0, aged, 1'b1);
  endfunction

  function automatic req_t mk(logic [2:0] f, logic [31:0] g, logic [47:0] rc,
                              logic [5:0] inst, logic [6:0] om, logic [63:0] h,
                              logic [31:0] now);
    req_t r;
    r.func = f; r.grp = g; r.rcpt = rc; r.inst = inst;
    r.omit = om; r.halted = h; r.now = now;
    return r;
  endfunction

  // random request drawn mostly from small pools so that members collide
  function automatic req_t rand_req();
    req_t r;
    int   k;
    k = $urandom_range(0, 99);
    if (k < 35)      r.func = mmt_pkg::FN_JOIN;
    else if (k < 50) r.func = mmt_pkg::FN_LEAVE;
    else if (k < 60) r.func = mmt_pkg::FN_AGE;
    else if (k < 65) r.func = mmt_pkg::FN_DROP;
    else if (k < 94) r.func = mmt_pkg::FN_FWD;
    else             r.func = 3'($urandom_range(FN_BAD5, FN_BAD7));
    if ($urandom_range(0, 9) == 0) begin
      r.grp  = $urandom;
      r.rcpt = {16'($urandom), 32'($urandom)};
      r.inst = 6'($urandom);
    end else begin
      r.grp  = 32'hE000_0000 | $urandom_range(0, 3);
      r.rcpt = {16'hA5A5, 32'($urandom_range(0, 7))};
      r.inst = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
    end
    k = $urandom_range(0, 3);
    r.omit = (k == 0) ? OMIT_NONE : (k == 1) ? 7'($urandom) : 7'($urandom_range(0, 5));
    k = $urandom_range(0, 3);
    r.halted = (k < 2) ? 64'd0 : (k == 2) ? {32'($urandom), 32'($urandom)}
                                          : 64'd1 << $urandom_range(0, 5);
    cur_now = cur_now + $urandom_range(0, 400);
    r.now = ($urandom_range(0, 19) == 0) ? 32'($urandom) : cur_now;
    return r;
  endfunction

  // wait until every request went in and every result came out
  task automatic drain();
    while (pend_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    int unsigned n;
    n = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    while (cfg_writes == n) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sender: bursts of transfers separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(negedge clk_i) begin
    req_t r;
    if (!in_valid_i || in_acc) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pend_q.size() > 0) begin
        r = pend_q.pop_front();
        func_i           <= r.func;
        group_addr_i     <= r.grp;
        recipient_addr_i <= r.rcpt;
        instance_req_i   <= r.inst;
        omit_instance_i  <= r.omit;
        halted_mask_i    <= r.halted;
        now_time_i       <= r.now;
        in_valid_i       <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(0, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern: periodic on/off, reshaped whenever stall_ph is a multiple of 64
  int unsigned stall_period = 4;
  int unsigned stall_on = 0;
  int unsigned stall_ph = 0;
  always @(negedge clk_i) begin
    if (stall_ph % 64 == 0) begin
      stall_period = $urandom_range(2, 9);
      stall_on     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
    end
    stall_ph++;
    out_stall_i <= (stall_ph % stall_period) < stall_on;
  end

  // request and config transfers update the mirror; result transfers are checked
  always @(posedge clk_i) begin
    res_t exp_r;
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("multicast_membership_table_tb: FAIL");
      $finish;
    end else begin
      in_acc <= in_valid_i && !in_stall_o;
      if (rst_ni && cfg_valid_i && cfg_ready_o) begin
        timeout_val = cfg_data_i;
        cfg_writes <= cfg_writes + 1;
      end
      if (rst_ni && in_valid_i && !in_stall_o)
        predict_membership(mk(func_i, group_addr_i, recipient_addr_i, instance_req_i,
                              omit_instance_i, halted_mask_i, now_time_i));
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: status %0d target %0d count %0d last %0b",
                     status_o, target_instance_o, removed_count_o, last_o);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r != {status_o, target_instance_o, removed_count_o, last_o}) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d tgt %0d cnt %0d last %0b, got %0d %0d %0d %0b",
                       exp_r.status, exp_r.tgt, exp_r.cnt, exp_r.last, status_o,
                       target_instance_o, removed_count_o, last_o);
          end
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    for (int i = 0; i < ENTRIES; i++) mem_valid[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every function and the named corner cases
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'hE000_0001, 48'd1, 6'd0, OMIT_NONE, '0,
                        32'd0));
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'hE000_0001, 48'd1, 6'd63, OMIT_NONE, '0,
                        32'd10));
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'hE000_0001, 48'd2, 6'd63, OMIT_NONE, '0,
                        32'd10));
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'hFFFF_FFFF, '1, 6'd63, OMIT_TOP, '1,
                        32'hFFFF_FFFF));
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'h0, 48'h0, 6'd5, OMIT_NONE, '0, 32'd20));
    pend_q.push_back(mk(mmt_pkg::FN_FWD, 32'hE000_0001, '0, '0, OMIT_NONE, '0, 32'd30));
    pend_q.push_back(mk(mmt_pkg::FN_FWD, 32'hE000_0001, '0, '0, 7'd0, '0, 32'd30));
    pend_q.push_back(mk(mmt_pkg::FN_FWD, 32'hE000_0001, '0, '0, OMIT_TOP,
                        64'h8000_0000_0000_0000, 32'd30));
    pend_q.push_back(mk(mmt_pkg::FN_FWD, 32'hE000_0001, '1, '1, OMIT_NONE, '1, 32'd30));
    pend_q.push_back(mk(mmt_pkg::FN_FWD, 32'h1234_5678, '0, '0, OMIT_NONE, '0, 32'd30));
    pend_q.push_back(mk(mmt_pkg::FN_LEAVE, 32'hE000_0001, 48'd2, 6'd0, OMIT_NONE, '0,
                        32'd40));
    pend_q.push_back(mk(mmt_pkg::FN_LEAVE, 32'hE000_0001, 48'd9, 6'd0, OMIT_NONE, '0,
                        32'd40));
    pend_q.push_back(mk(mmt_pkg::FN_AGE, '0, '0, 6'd0, OMIT_NONE, '0, 32'd270));
    pend_q.push_back(mk(mmt_pkg::FN_AGE, '0, '0, 6'd63, OMIT_NONE, '0, 32'hFFFF_FFFF));
    pend_q.push_back(mk(mmt_pkg::FN_DROP, '0, '0, 6'd5, OMIT_NONE, '0, 32'd0));
    pend_q.push_back(mk(FN_BAD5, 32'hE000_0001, 48'd1, 6'd0, OMIT_NONE, '0, 32'd0));
    pend_q.push_back(mk(3'd6, '0, '0, '0, OMIT_NONE, '0, 32'd0));
    pend_q.push_back(mk(FN_BAD7, '1, '1, '1, OMIT_TOP, '1, '1));
    drain();

    // zero timeout: a member expires on the next sweep at the same time
    write_timeout(16'd0);
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'hE000_0002, 48'd7, 6'd9, OMIT_NONE, '0,
                        32'd500));
    pend_q.push_back(mk(mmt_pkg::FN_FWD, 32'hE000_0002, '0, '0, OMIT_NONE, '0, 32'd500));
    pend_q.push_back(mk(mmt_pkg::FN_AGE, '0, '0, 6'd9, OMIT_NONE, '0, 32'd500));
    drain();

    // expiry saturation near the top of time
    write_timeout(16'hFFFF);
    pend_q.push_back(mk(mmt_pkg::FN_JOIN, 32'hE000_0003, 48'd3, 6'd1, OMIT_NONE, '0,
                        32'hFFFF_0001));
    pend_q.push_back(mk(mmt_pkg::FN_AGE, '0, '0, 6'd1, OMIT_NONE, '0, 32'hFFFF_FFFE));
    pend_q.push_back(mk(mmt_pkg::FN_AGE, '0, '0, 6'd1, OMIT_NONE, '0, 32'hFFFF_FFFF));
    drain();

    // random phases under several timeouts
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_timeout(16'd1);
        1: write_timeout(16'($urandom_range(100, 2000)));
        2: write_timeout(mmt_pkg::TIMEOUT_RESET);
        default: write_timeout(16'($urandom));
      endcase
      for (int i = 0; i < 32; i++) pend_q.push_back(rand_req());
      drain();
    end

    if (errors == 0 && expected_q.size() == 0) begin
      $display("multicast_membership_table_tb: PASS");
    end else begin
      $display("multicast_membership_table_tb: FAIL");
    end
    $finish;
  end
endmodule
